>>> rtl/ped_pkg.sv
// Shared types and constants for the percent-escape decoder.
// Depends on nothing; used by ped_decode, ped_outbuf and the top level.
package ped_pkg;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UA      = 8'h41;
	localparam logic [7:0] CH_UF      = 8'h46;
	localparam logic [7:0] CH_LA      = 8'h61;
	localparam logic [7:0] CH_LF      = 8'h66;

	localparam int unsigned MAX_OUT = 3;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_PCT  = 3'b010,
		PH_DIG  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] data;
		logic [1:0]              count;
		logic                    fin;
	} ped_res_t;

	function automatic logic is_hex(input logic [7:0] c);
		logic r;
		r = ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF))
			|| ((c >= CH_LA) && (c <= CH_LF));
		return r;
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		if ((c >= CH_0) && (c <= CH_9)) begin
			t = c - CH_0;
		end else if ((c >= CH_UA) && (c <= CH_UF)) begin
			t = c - (CH_UA - 8'd10);
		end else begin
			t = c - (CH_LA - 8'd10);
		end
		return t[3:0];
	endfunction

endpackage

>>> rtl/percent_escape_decoder_top.sv
// Top level of the streaming percent-escape decoder.
// Depends on ped_pkg, ped_decode and ped_outbuf.
//
// Decodes a URL percent-encoded byte stream: '+' becomes a space and "%hh"
// becomes the byte hh; malformed escapes pass through unchanged. Each input
// transaction is registered, decoded combinationally and placed in a result
// register that emits its 0 to 3 bytes one per cycle while m_axis_tready is
// high. Ordinary text flows at one byte per clock when the output does not
// stall; a malformed escape that yields two or three bytes holds the input
// side while the result register drains. m_axis_tlast marks the final byte
// caused by one input, m_axis_tuser the final byte of the string.
module percent_escape_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // in_byte[7:0]
	input  logic       s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte[7:0]
	output logic       m_axis_tlast,   // run_last
	output logic       m_axis_tuser    // string_end
);
	import ped_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       can_load;
	logic       advance;
	ped_res_t   res;

	assign advance       = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	ped_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (byte_s1),
		.last_in (last_s1),
		.advance (advance),
		.res     (res)
	);

	ped_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.load          (advance),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

`ifndef SYNTH
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("string end flagged on a byte that is not the last of its run");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)))
		else $error("result register overwritten before it drained");
`endif

endmodule

>>> rtl/ped_decode.sv
// Escape decoder: holds the escape phase and the pending digit, and turns one
// character into zero to three decoded bytes. Depends on ped_pkg.
module ped_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        char_in,
	input  logic              last_in,
	input  logic              advance,
	output ped_pkg::ped_res_t res
);
	import ped_pkg::*;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [7:0] held_q;
	logic [7:0] held_d;
	logic       hex;

	assign hex = is_hex(char_in);

	always_comb begin
		logic [1:0] n;
		logic       do_ord;
		logic       ord_last;
		n        = 2'd0;
		do_ord   = 1'b0;
		ord_last = last_in;
		res      = '0;
		phase_d  = PH_IDLE;
		held_d   = held_q;
		unique case (phase_q)
			PH_PCT: begin
				if (last_in) begin
					res.data[0] = CH_PERCENT;
					res.data[1] = char_in;
					n = 2'd2;
				end else if (hex) begin
					held_d  = char_in;
					phase_d = PH_DIG;
				end else begin
					res.data[0] = CH_PERCENT;
					n = 2'd1;
					do_ord   = 1'b1;
					ord_last = 1'b0;
				end
			end
			PH_DIG: begin
				if (hex) begin
					res.data[0] = {hex_val(held_q), hex_val(char_in)};
					n = 2'd1;
				end else begin
					res.data[0] = CH_PERCENT;
					res.data[1] = held_q;
					n = 2'd2;
					do_ord = 1'b1;
				end
			end
			default: begin
				do_ord = 1'b1;
			end
		endcase
		if (do_ord) begin
			if (char_in == CH_PLUS) begin
				res.data[n] = CH_SPACE;
				n = n + 2'd1;
			end else if (char_in == CH_PERCENT) begin
				if (ord_last) begin
					res.data[n] = CH_PERCENT;
					n = n + 2'd1;
				end else begin
					phase_d = PH_PCT;
				end
			end else begin
				res.data[n] = char_in;
				n = n + 2'd1;
			end
		end
		if (last_in) begin
			phase_d = PH_IDLE;
		end
		res.count = n;
		res.fin   = last_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'h00;
		end else if (advance) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

>>> rtl/ped_outbuf.sv
// Result register: holds the bytes of one decoded character and hands them
// out one transaction at a time. Depends on ped_pkg.
module ped_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  ped_pkg::ped_res_t res,
	input  logic              load,
	output logic              can_load,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,   // out_byte[7:0]
	output logic              m_axis_tlast,   // run_last
	output logic              m_axis_tuser    // string_end
);
	import ped_pkg::*;

	logic [MAX_OUT-1:0][7:0] data_s2;
	logic [1:0]              cnt_q;
	logic [1:0]              pos_q;
	logic                    fin_q;

	assign m_axis_tvalid = (pos_q != cnt_q);
	assign m_axis_tlast  = (pos_q == cnt_q - 2'd1);
	assign m_axis_tuser  = m_axis_tlast & fin_q;
	assign m_axis_tdata  = data_s2[pos_q];
	assign can_load      = !m_axis_tvalid || (m_axis_tready && m_axis_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			pos_q <= 2'd0;
			fin_q <= 1'b0;
		end else if (load) begin
			cnt_q <= res.count;
			pos_q <= 2'd0;
			fin_q <= res.fin;
		end else if (m_axis_tvalid && m_axis_tready) begin
			pos_q <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= res.data;
		end
	end

endmodule
